### sv/eht_pkg.sv
// Shared constants for the extendible hash table engine.
// Used by extendible_hash_table and eht_checker; depends on nothing.
`timescale 1ns / 1ps

package eht_pkg;

   localparam int MAX_GLOBAL_DEPTH   = 6;
   localparam int DIR_BITS           = MAX_GLOBAL_DEPTH;
   localparam int DIR_SIZE           = 1 << MAX_GLOBAL_DEPTH;
   localparam int GD_BITS            = $clog2(MAX_GLOBAL_DEPTH + 1);
   localparam int CNT_BITS           = MAX_GLOBAL_DEPTH + 1;
   localparam int LD_BITS            = GD_BITS + 1;
   localparam int CAP_BITS           = 5;
   localparam int CAP_RESET          = 16;
   localparam int OP_BITS            = 2;
   localparam int STATUS_BITS        = 2;

   localparam int DEF_BUCKET_SLOTS   = 16;
   localparam int DEF_KEY_BITS       = 32;
   localparam int DEF_VALUE_BITS     = 64;

   localparam logic [OP_BITS-1:0] OP_FIND   = 2'd0;
   localparam logic [OP_BITS-1:0] OP_INSERT = 2'd1;
   localparam logic [OP_BITS-1:0] OP_REMOVE = 2'd2;
   localparam logic [OP_BITS-1:0] OP_QUERY  = 2'd3;

   localparam logic [STATUS_BITS-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_NOTFOUND = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_FULL     = 2'd2;

   localparam logic signed [LD_BITS-1:0] LD_EMPTY = -1;

endpackage

### sv/extendible_hash_table.sv
// Extendible hash table engine: find, insert, remove and depth query.
// Each find, insert and remove scans its bucket, one bucket slot compared per cycle on
// the key/value memory read port; a depth query beyond the directory skips the reads.
// A split doubles the directory when the bucket's new depth exceeds it, moves entries
// to the new bucket, repoints directory slots and then retries the lookup.
// One item is handled at a time: req_stall stays high until it is answered. Reset is
// synchronous; afterwards a clearing pass over the directory runs while req_stall is high.
`timescale 1ns / 1ps

module extendible_hash_table import eht_pkg::*; #(
   parameter int BUCKET_SLOTS = DEF_BUCKET_SLOTS,
   parameter int KEY_BITS     = DEF_KEY_BITS,
   parameter int VALUE_BITS   = DEF_VALUE_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [CAP_BITS-1:0]           csr_wr_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [OP_BITS-1:0]            req_op,
   input  logic [KEY_BITS-1:0]           req_key,
   input  logic [VALUE_BITS-1:0]         req_value_in,
   input  logic [DIR_BITS-1:0]           req_dir_slot,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [STATUS_BITS-1:0]        rsp_status,
   output logic [VALUE_BITS-1:0]         rsp_value_out,
   output logic [GD_BITS-1:0]            rsp_global_depth,
   output logic [CNT_BITS-1:0]           rsp_bucket_count,
   output logic signed [LD_BITS-1:0]     rsp_local_depth
);

   localparam int SLOT_BITS = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;
   localparam int IDX_BITS  = SLOT_BITS + 1;
   localparam int SCNT_BITS = $clog2(BUCKET_SLOTS + 1);
   localparam int KV_DEPTH  = DIR_SIZE * (1 << SLOT_BITS);
   localparam int KV_BITS   = DIR_BITS + SLOT_BITS;

   localparam logic [3:0] S_CLEAR   = 4'd0;
   localparam logic [3:0] S_IDLE    = 4'd1;
   localparam logic [3:0] S_LOOK    = 4'd2;
   localparam logic [3:0] S_DIR     = 4'd3;
   localparam logic [3:0] S_BKT     = 4'd4;
   localparam logic [3:0] S_SCAN    = 4'd5;
   localparam logic [3:0] S_DECIDE  = 4'd6;
   localparam logic [3:0] S_COPY    = 4'd7;
   localparam logic [3:0] S_SPLIT   = 4'd8;
   localparam logic [3:0] S_MOVE    = 4'd9;
   localparam logic [3:0] S_ROWB    = 4'd10;
   localparam logic [3:0] S_ROWN    = 4'd11;
   localparam logic [3:0] S_REPOINT = 4'd12;
   localparam logic [3:0] S_DONE    = 4'd13;

   localparam logic [IDX_BITS-1:0] BS_W = IDX_BITS'(BUCKET_SLOTS);

   // Memories.
   logic [DIR_BITS-1:0]     dir_mem   [DIR_SIZE];
   logic [GD_BITS-1:0]      depth_mem [DIR_SIZE];
   logic [BUCKET_SLOTS-1:0] row_mem   [DIR_SIZE];
   logic [KEY_BITS-1:0]     key_mem   [KV_DEPTH];
   logic [VALUE_BITS-1:0]   val_mem   [KV_DEPTH];

   logic [DIR_BITS-1:0]     dir_rd_ff, dir_raddr, dir_waddr, dir_wdata;
   logic                    dir_we;
   logic [GD_BITS-1:0]      depth_rd_ff, depth_wdata;
   logic [DIR_BITS-1:0]     depth_raddr, depth_waddr;
   logic                    depth_we;
   logic [BUCKET_SLOTS-1:0] row_rd_ff, row_wdata;
   logic [DIR_BITS-1:0]     row_raddr, row_waddr;
   logic                    row_we;
   logic [KEY_BITS-1:0]     key_rd_ff, kv_wkey;
   logic [VALUE_BITS-1:0]   val_rd_ff, kv_wval;
   logic [KV_BITS-1:0]      kv_raddr, kv_waddr;
   logic                    kv_we;

   // Sequencer registers.
   logic [3:0]              state_ff, state_in;
   logic [DIR_BITS-1:0]     clr_ff, clr_in;
   logic [OP_BITS-1:0]      op_ff, op_in;
   logic [KEY_BITS-1:0]     key_ff, key_in;
   logic [VALUE_BITS-1:0]   val_ff, val_in;
   logic [DIR_BITS-1:0]     slot_ff, slot_in;
   logic [DIR_BITS-1:0]     b_ff, b_in;
   logic [BUCKET_SLOTS-1:0] row_ff, row_in;
   logic [GD_BITS-1:0]      bdepth_ff, bdepth_in;
   logic [GD_BITS-1:0]      gd_ff, gd_in;
   logic [CNT_BITS-1:0]     used_ff, used_in;
   logic [CAP_BITS-1:0]     cap_ff, cap_in;
   logic [IDX_BITS-1:0]     idx_ff, idx_in;
   logic                    pend_ff, pend_in;
   logic [SLOT_BITS-1:0]    pslot_ff, pslot_in;
   logic                    hit_ff, hit_in;
   logic [SLOT_BITS-1:0]    hit_slot_ff, hit_slot_in;
   logic [VALUE_BITS-1:0]   hit_val_ff, hit_val_in;
   logic                    free_ff, free_in;
   logic [SLOT_BITS-1:0]    free_slot_ff, free_slot_in;
   logic [SCNT_BITS-1:0]    cnt_ff, cnt_in;
   logic [DIR_BITS-1:0]     nb_ff, nb_in;
   logic [GD_BITS-1:0]      sbit_ff, sbit_in;
   logic [BUCKET_SLOTS-1:0] row_nb_ff, row_nb_in;
   logic [DIR_BITS:0]       i_ff, i_in;
   logic                    pipe_ff, pipe_in;
   logic [DIR_BITS-1:0]     pidx_ff, pidx_in;
   logic [STATUS_BITS-1:0]  res_status_ff, res_status_in;
   logic [VALUE_BITS-1:0]   res_val_ff, res_val_in;
   logic signed [LD_BITS-1:0] res_ld_ff, res_ld_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0]  o_status_ff, o_status_in;
   logic [VALUE_BITS-1:0]   o_val_ff, o_val_in;
   logic [GD_BITS-1:0]      o_gd_ff, o_gd_in;
   logic [CNT_BITS-1:0]     o_cnt_ff, o_cnt_in;
   logic signed [LD_BITS-1:0] o_ld_ff, o_ld_in;

   logic [DIR_BITS:0]       dir_size;
   logic [7:0]              cap_wide;
   logic [SCNT_BITS-1:0]    cap_eff;
   logic                    pend_bit;
   logic [GD_BITS-1:0]      new_depth;

   assign dir_size  = (DIR_BITS + 1)'(1) << gd_ff;
   assign pend_bit  = row_ff[pslot_ff];
   assign new_depth = bdepth_ff + GD_BITS'(1);

   always_comb begin
      cap_wide = {3'b000, cap_ff};
      if (cap_wide == 8'd0) begin
         cap_wide = 8'd1;
      end else if (cap_wide > 8'(BUCKET_SLOTS)) begin
         cap_wide = 8'(BUCKET_SLOTS);
      end
      cap_eff = SCNT_BITS'(cap_wide);
   end

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      val_in        = val_ff;
      slot_in       = slot_ff;
      b_in          = b_ff;
      row_in        = row_ff;
      bdepth_in     = bdepth_ff;
      gd_in         = gd_ff;
      used_in       = used_ff;
      cap_in        = csr_wr_en ? csr_wr_data : cap_ff;
      idx_in        = idx_ff;
      pend_in       = pend_ff;
      pslot_in      = pslot_ff;
      hit_in        = hit_ff;
      hit_slot_in   = hit_slot_ff;
      hit_val_in    = hit_val_ff;
      free_in       = free_ff;
      free_slot_in  = free_slot_ff;
      cnt_in        = cnt_ff;
      nb_in         = nb_ff;
      sbit_in       = sbit_ff;
      row_nb_in     = row_nb_ff;
      i_in          = i_ff;
      pipe_in       = pipe_ff;
      pidx_in       = pidx_ff;
      res_status_in = res_status_ff;
      res_val_in    = res_val_ff;
      res_ld_in     = res_ld_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      o_status_in   = o_status_ff;
      o_val_in      = o_val_ff;
      o_gd_in       = o_gd_ff;
      o_cnt_in      = o_cnt_ff;
      o_ld_in       = o_ld_ff;

      dir_raddr   = '0;
      dir_we      = 1'b0;
      dir_waddr   = '0;
      dir_wdata   = '0;
      depth_raddr = '0;
      depth_we    = 1'b0;
      depth_waddr = '0;
      depth_wdata = '0;
      row_raddr   = '0;
      row_we      = 1'b0;
      row_waddr   = '0;
      row_wdata   = '0;
      kv_raddr    = '0;
      kv_we       = 1'b0;
      kv_waddr    = '0;
      kv_wkey     = key_ff;
      kv_wval     = val_ff;

      unique case (state_ff)
         S_CLEAR: begin
            dir_we      = 1'b1;
            dir_waddr   = clr_ff;
            depth_we    = 1'b1;
            depth_waddr = clr_ff;
            row_we      = 1'b1;
            row_waddr   = clr_ff;
            clr_in      = clr_ff + DIR_BITS'(1);
            if (clr_ff == DIR_BITS'(DIR_SIZE - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               op_in         = req_op;
               key_in        = req_key;
               val_in        = req_value_in;
               slot_in       = req_dir_slot;
               res_status_in = ST_OK;
               res_val_in    = '0;
               res_ld_in     = '0;
               state_in      = S_LOOK;
            end
         end
         S_LOOK: begin
            if (op_ff == OP_QUERY) begin
               dir_raddr = slot_ff;
               if ({1'b0, slot_ff} >= dir_size) begin
                  res_ld_in = LD_EMPTY;
                  state_in  = S_DONE;
               end else begin
                  state_in  = S_DIR;
               end
            end else begin
               dir_raddr = key_ff[DIR_BITS-1:0] & DIR_BITS'(dir_size - (DIR_BITS + 1)'(1));
               state_in  = S_DIR;
            end
         end
         S_DIR: begin
            b_in        = dir_rd_ff;
            row_raddr   = dir_rd_ff;
            depth_raddr = dir_rd_ff;
            state_in    = S_BKT;
         end
         S_BKT: begin
            row_in    = row_rd_ff;
            bdepth_in = depth_rd_ff;
            if (op_ff == OP_QUERY) begin
               res_ld_in = (row_rd_ff == '0) ? LD_EMPTY : $signed({1'b0, depth_rd_ff});
               state_in  = S_DONE;
            end else begin
               idx_in   = '0;
               pend_in  = 1'b0;
               hit_in   = 1'b0;
               free_in  = 1'b0;
               cnt_in   = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            // One slot read is issued per cycle; its compare happens in the next cycle.
            if (idx_ff < BS_W) begin
               kv_raddr = {b_ff, idx_ff[SLOT_BITS-1:0]};
               pend_in  = 1'b1;
               pslot_in = idx_ff[SLOT_BITS-1:0];
               idx_in   = idx_ff + IDX_BITS'(1);
            end else begin
               pend_in  = 1'b0;
            end
            if (pend_ff) begin
               if (pend_bit) begin
                  cnt_in = cnt_ff + SCNT_BITS'(1);
                  if (key_rd_ff == key_ff) begin
                     hit_in      = 1'b1;
                     hit_slot_in = pslot_ff;
                     hit_val_in  = val_rd_ff;
                  end
               end else if (!free_ff) begin
                  free_in      = 1'b1;
                  free_slot_in = pslot_ff;
               end
            end
            if (idx_ff == BS_W && !pend_ff) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            state_in = S_DONE;
            unique case (op_ff)
               OP_FIND: begin
                  if (hit_ff) begin
                     res_val_in = hit_val_ff;
                  end else begin
                     res_status_in = ST_NOTFOUND;
                  end
               end
               OP_REMOVE: begin
                  if (hit_ff) begin
                     row_we    = 1'b1;
                     row_waddr = b_ff;
                     row_wdata = row_ff & ~(BUCKET_SLOTS'(1) << hit_slot_ff);
                  end else begin
                     res_status_in = ST_NOTFOUND;
                  end
               end
               OP_INSERT: begin
                  priority if (hit_ff) begin
                     kv_we    = 1'b1;
                     kv_waddr = {b_ff, hit_slot_ff};
                  end else if (cnt_ff < cap_eff) begin
                     if (free_ff) begin
                        kv_we     = 1'b1;
                        kv_waddr  = {b_ff, free_slot_ff};
                        row_we    = 1'b1;
                        row_waddr = b_ff;
                        row_wdata = row_ff | (BUCKET_SLOTS'(1) << free_slot_ff);
                     end else begin
                        res_status_in = ST_FULL;
                     end
                  end else if (bdepth_ff >= GD_BITS'(MAX_GLOBAL_DEPTH)) begin
                     res_status_in = ST_FULL;
                  end else begin
                     // Split on the bit just above the bucket's current depth.
                     depth_we    = 1'b1;
                     depth_waddr = b_ff;
                     depth_wdata = new_depth;
                     sbit_in     = bdepth_ff;
                     nb_in       = used_ff[DIR_BITS-1:0];
                     used_in     = used_ff + CNT_BITS'(1);
                     i_in        = '0;
                     pipe_in     = 1'b0;
                     state_in    = (new_depth > gd_ff) ? S_COPY : S_SPLIT;
                  end
               end
               default: begin
                  res_status_in = ST_OK;
               end
            endcase
         end
         S_COPY: begin
            // Doubling: the upper half of the directory mirrors the lower half.
            if (i_ff < dir_size) begin
               dir_raddr = i_ff[DIR_BITS-1:0];
               pipe_in   = 1'b1;
               pidx_in   = i_ff[DIR_BITS-1:0];
               i_in      = i_ff + (DIR_BITS + 1)'(1);
            end else begin
               pipe_in   = 1'b0;
            end
            if (pipe_ff) begin
               dir_we    = 1'b1;
               dir_waddr = pidx_ff + dir_size[DIR_BITS-1:0];
               dir_wdata = dir_rd_ff;
            end
            if (i_ff == dir_size && !pipe_ff) begin
               gd_in    = gd_ff + GD_BITS'(1);
               state_in = S_SPLIT;
            end
         end
         S_SPLIT: begin
            depth_we    = 1'b1;
            depth_waddr = nb_ff;
            depth_wdata = new_depth;
            idx_in      = '0;
            pend_in     = 1'b0;
            row_nb_in   = '0;
            state_in    = S_MOVE;
         end
         S_MOVE: begin
            if (idx_ff < BS_W) begin
               kv_raddr = {b_ff, idx_ff[SLOT_BITS-1:0]};
               pend_in  = 1'b1;
               pslot_in = idx_ff[SLOT_BITS-1:0];
               idx_in   = idx_ff + IDX_BITS'(1);
            end else begin
               pend_in  = 1'b0;
            end
            if (pend_ff && pend_bit && key_rd_ff[sbit_ff]) begin
               kv_we     = 1'b1;
               kv_waddr  = {nb_ff, pslot_ff};
               kv_wkey   = key_rd_ff;
               kv_wval   = val_rd_ff;
               row_in    = row_ff & ~(BUCKET_SLOTS'(1) << pslot_ff);
               row_nb_in = row_nb_ff | (BUCKET_SLOTS'(1) << pslot_ff);
            end
            if (idx_ff == BS_W && !pend_ff) begin
               state_in = S_ROWB;
            end
         end
         S_ROWB: begin
            row_we    = 1'b1;
            row_waddr = b_ff;
            row_wdata = row_ff;
            state_in  = S_ROWN;
         end
         S_ROWN: begin
            row_we    = 1'b1;
            row_waddr = nb_ff;
            row_wdata = row_nb_ff;
            i_in      = '0;
            pipe_in   = 1'b0;
            state_in  = S_REPOINT;
         end
         S_REPOINT: begin
            if (i_ff < dir_size) begin
               dir_raddr = i_ff[DIR_BITS-1:0];
               pipe_in   = 1'b1;
               pidx_in   = i_ff[DIR_BITS-1:0];
               i_in      = i_ff + (DIR_BITS + 1)'(1);
            end else begin
               pipe_in   = 1'b0;
            end
            if (pipe_ff && dir_rd_ff == b_ff && pidx_ff[sbit_ff]) begin
               dir_we    = 1'b1;
               dir_waddr = pidx_ff;
               dir_wdata = nb_ff;
            end
            if (i_ff == dir_size && !pipe_ff) begin
               // Retry the insert against the new layout.
               state_in = S_LOOK;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               o_status_in  = res_status_ff;
               o_val_in     = res_val_ff;
               o_gd_in      = gd_ff;
               o_cnt_in     = used_ff;
               o_ld_in      = res_ld_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (dir_we) begin
         dir_mem[dir_waddr] <= dir_wdata;
      end
      dir_rd_ff <= dir_mem[dir_raddr];
      if (depth_we) begin
         depth_mem[depth_waddr] <= depth_wdata;
      end
      depth_rd_ff <= depth_mem[depth_raddr];
      if (row_we) begin
         row_mem[row_waddr] <= row_wdata;
      end
      row_rd_ff <= row_mem[row_raddr];
      if (kv_we) begin
         key_mem[kv_waddr] <= kv_wkey;
         val_mem[kv_waddr] <= kv_wval;
      end
      key_rd_ff <= key_mem[kv_raddr];
      val_rd_ff <= val_mem[kv_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         gd_ff        <= '0;
         used_ff      <= CNT_BITS'(1);
         cap_ff       <= CAP_BITS'(CAP_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         gd_ff        <= gd_in;
         used_ff      <= used_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      slot_ff       <= slot_in;
      b_ff          <= b_in;
      row_ff        <= row_in;
      bdepth_ff     <= bdepth_in;
      idx_ff        <= idx_in;
      pend_ff       <= pend_in;
      pslot_ff      <= pslot_in;
      hit_ff        <= hit_in;
      hit_slot_ff   <= hit_slot_in;
      hit_val_ff    <= hit_val_in;
      free_ff       <= free_in;
      free_slot_ff  <= free_slot_in;
      cnt_ff        <= cnt_in;
      nb_ff         <= nb_in;
      sbit_ff       <= sbit_in;
      row_nb_ff     <= row_nb_in;
      i_ff          <= i_in;
      pipe_ff       <= pipe_in;
      pidx_ff       <= pidx_in;
      res_status_ff <= res_status_in;
      res_val_ff    <= res_val_in;
      res_ld_ff     <= res_ld_in;
      o_status_ff   <= o_status_in;
      o_val_ff      <= o_val_in;
      o_gd_ff       <= o_gd_in;
      o_cnt_ff      <= o_cnt_in;
      o_ld_ff       <= o_ld_in;
   end

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = o_status_ff;
   assign rsp_value_out    = o_val_ff;
   assign rsp_global_depth = o_gd_ff;
   assign rsp_bucket_count = o_cnt_ff;
   assign rsp_local_depth  = o_ld_ff;

endmodule

### sv/eht_checker.sv
// Port-level checks for extendible_hash_table, attached by the bind below.
// Depends on eht_pkg.
`timescale 1ns / 1ps

module eht_checker import eht_pkg::*; #(
   parameter int VALUE_BITS = DEF_VALUE_BITS
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_stall,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic [STATUS_BITS-1:0]    rsp_status,
   input logic [VALUE_BITS-1:0]     rsp_value_out,
   input logic [GD_BITS-1:0]        rsp_global_depth,
   input logic [CNT_BITS-1:0]       rsp_bucket_count,
   input logic signed [LD_BITS-1:0] rsp_local_depth
);

   // A stalled item holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) && $stable(rsp_value_out))
      else $error("stalled result item changed");

   // The clearing pass keeps the input side closed right after reset.
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_stall)
      else $error("item accepted during clearing pass");

   // Depth within MAX_GLOBAL_DEPTH; bucket count from 1 to DIR_SIZE.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_global_depth <= GD_BITS'(MAX_GLOBAL_DEPTH)
                    && rsp_bucket_count != '0
                    && rsp_bucket_count <= CNT_BITS'(DIR_SIZE))
      else $error("global depth or bucket count out of range");

   // Only a depth query reports a local depth, and it always succeeds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_local_depth != '0 |-> rsp_status == ST_OK && rsp_value_out == '0)
      else $error("local depth reported with a failing status");

endmodule

bind extendible_hash_table eht_checker #(.VALUE_BITS(VALUE_BITS)) u_eht_checker (.*);
